// File: rtl/tiaf_pkg.sv
// telnet iac filter ring writer: shared types and constants
// no dependencies; imported by every module of the block

package tiaf_pkg;

    localparam int unsigned RING_DEPTH = 4096;
    localparam int unsigned HEAD_W     = $clog2(RING_DEPTH);
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned CNT_W      = $clog2(HEAD_W + 1);

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(RING_DEPTH);

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_LF   = 8'h0a;

    typedef enum logic [1:0] {
        OP_DATA       = 2'd0,
        OP_CONNECT    = 2'd1,
        OP_DISCONNECT = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        P_DATA   = 5'b00001,
        P_CMD    = 5'b00010,
        P_OPT    = 5'b00100,
        P_SUB    = 5'b01000,
        P_SUBIAC = 5'b10000
    } parser_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hm_status_t;

endpackage

// File: rtl/tiaf_head_mod.sv
// telnet iac filter ring writer: restoring remainder unit, head modulo ring size
// depends on tiaf_pkg; one quotient bit per cycle

module tiaf_head_mod
    import tiaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HEAD_W-1:0] head,
    input  logic [SIZE_W-1:0] size,
    output hm_status_t        status,
    output logic [HEAD_W-1:0] rem
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HEAD_W-1:0] div_reg, div_next;
    logic [HEAD_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] shifted;

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, div_reg[HEAD_W-1]};
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(HEAD_W);
            div_next = head;
            rem_next = '0;
        end else if (run_reg) begin
            div_next = {div_reg[HEAD_W-2:0], 1'b0};
            if (shifted >= size) begin
                rem_next = HEAD_W'(shifted - size);
            end else begin
                rem_next = HEAD_W'(shifted);
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.busy = run_reg | done_reg;
    assign status.done = done_reg;
    assign rem         = rem_reg;

endmodule

// File: rtl/telnet_iac_filter_ring_writer.sv
// The result transaction is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; after a
// ring_size write the input stalls while the head is reduced modulo the new size.
// Reset (aresetn low, synchronous): parser to normal data, head 0,
// not dropping, ring_size 4096, output empty.
// depends on tiaf_pkg and tiaf_head_mod

module telnet_iac_filter_ring_writer
    import tiaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // rx_byte, chunk_start, consumer_tail, zero pad
    input  logic [1:0]        s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // write_index, write_data, producer_head
    output logic [1:0]        m_tuser    // write_valid, ring_full_drop
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [HEAD_W-1:0] hmod_reg, hmod_next;
    parser_t           pstate_reg, pstate_next;
    logic              drop_reg, drop_next;
    logic              start_reg;
    logic              m_valid_reg;
    logic              wv_reg, wv_next;
    logic [HEAD_W-1:0] widx_reg, widx_next;
    logic [7:0]        wdata_reg, wdata_next;
    logic [HEAD_W-1:0] phead_reg;
    logic              fdrop_reg, fdrop_next;

    hm_status_t        hm_status;
    logic [HEAD_W-1:0] hm_rem;

    op_t               op;
    logic [7:0]        ch;
    logic              chunk;
    logic [HEAD_W-1:0] tail;
    logic              accept;
    logic [HEAD_W-1:0] h_inc;
    logic              full;
    logic              put_req;
    logic              put_setdrop;
    logic [7:0]        put_byte;
    logic              dropping;

    assign op    = op_t'(s_tuser);
    assign ch    = s_tdata[7:0];
    assign chunk = s_tdata[8];
    assign tail  = s_tdata[20:9];

    assign s_tready = !hm_status.busy && !start_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    tiaf_head_mod u_head_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .head    (head_reg),
        .size    (size_reg),
        .status  (hm_status),
        .rem     (hm_rem)
    );

    always_comb begin
        if (cfg_wdata < SIZE_MIN) begin
            size_next = SIZE_MIN;
        end else if (cfg_wdata > SIZE_MAX) begin
            size_next = SIZE_MAX;
        end else begin
            size_next = cfg_wdata;
        end
    end

    // ring slot arithmetic on the reduced head
    assign h_inc = ({1'b0, hmod_reg} + SIZE_W'(1) == size_reg) ? '0 : hmod_reg + HEAD_W'(1);
    assign full  = (h_inc == tail);

    always_comb begin
        pstate_next = pstate_reg;
        drop_next   = drop_reg;
        put_req     = 1'b0;
        put_setdrop = 1'b0;
        put_byte    = ch;
        fdrop_next  = 1'b0;
        dropping    = drop_reg && !chunk;
        case (op)
            OP_CONNECT: begin
                pstate_next = P_DATA;
                drop_next   = 1'b0;
                put_req     = 1'b1;
                put_byte    = B_LF;
            end
            OP_DISCONNECT: begin
                pstate_next = P_DATA;
                drop_next   = 1'b0;
            end
            OP_DATA: begin
                drop_next = dropping;
                if (dropping) begin
                    fdrop_next = 1'b1;
                end else begin
                    case (pstate_reg)
                        P_SUB: begin
                            if (ch == B_IAC) pstate_next = P_SUBIAC;
                        end
                        P_SUBIAC: begin
                            if (ch == B_SE) begin
                                pstate_next = P_DATA;
                            end else if (ch != B_IAC) begin
                                pstate_next = P_SUB;
                            end
                        end
                        P_CMD: begin
                            if (ch == B_IAC) begin
                                pstate_next = P_DATA;
                                put_req     = 1'b1;
                                put_setdrop = 1'b1;
                                put_byte    = B_IAC;
                            end else if (ch >= B_WILL && ch <= B_DONT) begin
                                pstate_next = P_OPT;
                            end else if (ch == B_SB) begin
                                pstate_next = P_SUB;
                            end else begin
                                pstate_next = P_DATA;
                            end
                        end
                        P_OPT: begin
                            pstate_next = P_DATA;
                        end
                        default: begin
                            if (ch == B_IAC) begin
                                pstate_next = P_CMD;
                            end else begin
                                pstate_next = P_DATA;
                                put_req     = 1'b1;
                                put_setdrop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        head_next  = head_reg;
        hmod_next  = hmod_reg;
        wv_next    = 1'b0;
        widx_next  = '0;
        wdata_next = '0;
        if (put_req) begin
            if (full) begin
                head_next  = hmod_reg;
                fdrop_next = 1'b1;
                if (put_setdrop) drop_next = 1'b1;
            end else begin
                head_next  = h_inc;
                hmod_next  = h_inc;
                wv_next    = 1'b1;
                widx_next  = hmod_reg;
                wdata_next = put_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_MAX;
            head_reg    <= '0;
            hmod_reg    <= '0;
            pstate_reg  <= P_DATA;
            drop_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= cfg_we;
            if (cfg_we) size_reg <= size_next;
            if (hm_status.done) begin
                hmod_reg <= hm_rem;
            end else if (accept) begin
                hmod_reg <= hmod_next;
            end
            if (accept) begin
                head_reg   <= head_next;
                pstate_reg <= pstate_next;
                drop_reg   <= drop_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            wv_reg    <= wv_next;
            widx_reg  <= widx_next;
            wdata_reg <= wdata_next;
            phead_reg <= head_next;
            fdrop_reg <= fdrop_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {phead_reg, wdata_reg, widx_reg};
    assign m_tuser  = {fdrop_reg, wv_reg};

endmodule

// File: rtl/tiaf_checker.sv
// telnet iac filter ring writer: port-level checks over time
// depends on tiaf_pkg; bound to telnet_iac_filter_ring_writer below

module tiaf_checker
    import tiaf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a ring write never also reports a full-ring drop
    a_write_or_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("write and drop in one transaction");

    // a write advances the head past the slot written
    a_head_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:20] != m_tdata[11:0])
        else $error("head not advanced by write");

    // a transaction without a write leaves index and data at zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[19:0] == 20'd0)
        else $error("write fields set without a write");

    // the head is reduced before the next input transaction
    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input taken during head reduction");

endmodule

bind telnet_iac_filter_ring_writer tiaf_checker u_tiaf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_we   (cfg_we),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
